@@ design/ctd_pkg.sv @@
package ctd_pkg;

  localparam int FRACTION_DEPTH_DEF = 32;
  localparam int QUEUE_DEPTH        = 4;

  localparam logic [15:0] CH_NL        = 16'h000A;
  localparam logic [15:0] CH_SPACE     = 16'h0020;
  localparam logic [15:0] CH_HASH      = 16'h0023;
  localparam logic [15:0] CH_PCT       = 16'h0025;
  localparam logic [15:0] CH_PLUS      = 16'h002B;
  localparam logic [15:0] CH_SLASH     = 16'h002F;
  localparam logic [15:0] CH_SEMI      = 16'h003B;
  localparam logic [15:0] CH_BSLASH    = 16'h005C;
  localparam logic [15:0] CH_CARET     = 16'h005E;
  localparam logic [15:0] CH_LBRACE    = 16'h007B;
  localparam logic [15:0] CH_RBRACE    = 16'h007D;
  localparam logic [15:0] CH_TILDE     = 16'h007E;
  localparam logic [15:0] CH_U         = 16'h0055;
  localparam logic [15:0] SYM_DEGREE   = 16'h00B0;
  localparam logic [15:0] SYM_DIAMETER = 16'h00D8;
  localparam logic [15:0] SYM_PLUSMIN  = 16'h00B1;

  typedef enum logic [2:0] {
    PH_TEXT, PH_ESC, PH_FRAC, PH_FRAC_OVF, PH_HEX, PH_SKIP
  } esc_phase_t;

  typedef enum logic [1:0] {
    PC_NONE, PC_ONE, PC_TWO
  } pct_phase_t;

  typedef enum logic [3:0] {
    F_IDLE, F_DECODE, F_HEX_U, F_HEX_OUT, F_TAIL, F_FLUSH,
    F_FRAC_ADDR, F_FRAC_DATA, F_END
  } front_state_t;

  typedef struct packed {
    logic [15:0] unit;
    logic        is_end;
    logic        first;
    logic        ovf;
    logic        last;
  } token_t;

  function automatic logic is_space(input logic [15:0] u);
    return (u >= 16'h0009 && u <= 16'h000D) || u == 16'h0020 || u == 16'h0085 ||
           u == 16'h00A0 || u == 16'h1680 || (u >= 16'h2000 && u <= 16'h200A) ||
           u == 16'h2028 || u == 16'h2029 || u == 16'h202F || u == 16'h205F ||
           u == 16'h3000;
  endfunction

  function automatic logic is_hex(input logic [15:0] u);
    return (u >= 16'h0030 && u <= 16'h0039) || (u >= 16'h0061 && u <= 16'h0066) ||
           (u >= 16'h0041 && u <= 16'h0046);
  endfunction

  function automatic logic [3:0] hex_nib(input logic [15:0] u);
    logic [15:0] d;
    d = 16'h0;
    if (u >= 16'h0030 && u <= 16'h0039) begin
      d = u - 16'h0030;
    end else if (u >= 16'h0061 && u <= 16'h0066) begin
      d = u - 16'h0057;
    end else begin
      d = u - 16'h0037;
    end
    return d[3:0];
  endfunction

endpackage

@@ design/ctd_if.sv @@
interface ctd_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        last;
  modport source (output valid, code_unit, last, input ready);
  modport sink (input valid, code_unit, last, output ready);
endinterface

interface ctd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_unit;
  logic        has_char;
  logic        end_of_string;
  logic        fraction_overflow;
  modport source (output valid, out_unit, has_char, end_of_string, fraction_overflow,
                  input ready);
  modport sink (input valid, out_unit, has_char, end_of_string, fraction_overflow,
                output ready);
endinterface

@@ design/ctd_queue.sv @@
module ctd_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ctd_pkg::token_t wdata,
  output logic            full,
  input  logic            pop,
  output ctd_pkg::token_t rdata,
  output logic            empty
);
  import ctd_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  token_t        slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      count <= count + CW'(push && !full) - CW'(pop && !empty);
    end
  end

`ifndef SYNTHESIS
  a_no_overrun: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue push while full");
  a_no_underrun: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue pop while empty");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !full && !(pop && !empty)) |=> count == $past(count) + CW'(1))
    else $error("queue count did not advance on push");
`endif

endmodule

@@ design/ctd_front.sv @@
module ctd_front #(
  parameter int FRACTION_DEPTH = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            rich_mode,
  ctd_in_if.sink          din,
  output ctd_pkg::token_t tok,
  output logic            tok_push,
  input  logic            tok_full
);
  import ctd_pkg::*;

  localparam int CW = $clog2(FRACTION_DEPTH + 1);
  localparam int AW = $clog2(FRACTION_DEPTH);

  front_state_t state, state_next;
  esc_phase_t   phase, phase_next;

  logic [15:0]   unit_r;
  logic          last_r;
  logic          first_pend;
  logic          item_ovf;
  logic          tail_pend, tail_pend_next;
  logic [CW-1:0] fcount, fcount_next;
  logic [CW-1:0] fend, fend_next;
  logic [CW-1:0] fidx, fidx_next;
  logic [15:0]   fmem [FRACTION_DEPTH];
  logic [15:0]   frd;
  logic          fwe;
  logic [15:0]   fwd;
  logic [2:0]    hcount, hcount_next;
  logic [2:0]    hidx, hidx_next;
  logic [15:0]   hstore [4];
  logic          hwe;
  logic [11:0]   hacc, hacc_next;

  // decode of one unit
  logic        d_emit;
  logic [15:0] d_unit;
  esc_phase_t  d_phase;
  logic        d_fstore, d_fclear, d_fstart, d_hstore, d_hclear, d_hexfail, d_ovf;
  logic        d_is_frac, hex_ok;
  logic [15:0] v;
  logic        t_emit;
  esc_phase_t  t_phase;

  assign v         = (unit_r == CH_CARET || unit_r == CH_HASH) ? CH_SLASH : unit_r;
  assign d_is_frac = (phase == PH_FRAC || phase == PH_FRAC_OVF);
  assign hex_ok    = (hcount == 3'd0) ? (unit_r == CH_PLUS) : is_hex(unit_r);

  // plain text rule shared by decode and the tail after a failed hex run
  always_comb begin
    t_emit  = 1'b0;
    t_phase = PH_TEXT;
    if (unit_r == CH_LBRACE || unit_r == CH_RBRACE) begin
      t_emit = 1'b0;
    end else if (unit_r == CH_BSLASH) begin
      t_phase = PH_ESC;
    end else begin
      t_emit = 1'b1;
    end
  end

  always_comb begin
    d_emit    = 1'b0;
    d_unit    = unit_r;
    d_phase   = phase;
    d_fstore  = 1'b0;
    d_fclear  = 1'b0;
    d_fstart  = 1'b0;
    d_hstore  = 1'b0;
    d_hclear  = 1'b0;
    d_hexfail = 1'b0;
    if (!rich_mode) begin
      d_emit = 1'b1;
    end else begin
      unique case (phase)
        PH_ESC: begin
          d_phase = PH_TEXT;
          unique case (unit_r)
            CH_BSLASH, CH_LBRACE, CH_RBRACE: d_emit = 1'b1;
            16'h0050, 16'h004E, 16'h0058: begin
              d_emit = 1'b1;
              d_unit = CH_NL;
            end
            CH_TILDE: begin
              d_emit = 1'b1;
              d_unit = CH_SPACE;
            end
            16'h004C, 16'h006C, 16'h004F, 16'h006F, 16'h004B, 16'h006B: d_emit = 1'b0;
            16'h0053: begin
              d_fclear = 1'b1;
              d_phase  = PH_FRAC;
            end
            CH_U: begin
              d_hclear = 1'b1;
              d_phase  = PH_HEX;
            end
            16'h0041, 16'h0043, 16'h0063, 16'h0046, 16'h0066, 16'h0048,
            16'h0057, 16'h0054, 16'h0051, 16'h0070: d_phase = PH_SKIP;
            default: d_emit = 1'b1;
          endcase
        end
        PH_FRAC, PH_FRAC_OVF: begin
          if (unit_r == CH_SEMI) begin
            d_fstart = 1'b1;
            d_phase  = PH_TEXT;
          end else if (fcount == '0 && is_space(v)) begin
            d_fstore = 1'b0;
          end else if (fcount < CW'(FRACTION_DEPTH)) begin
            d_fstore = 1'b1;
          end else if (!is_space(v)) begin
            d_phase = PH_FRAC_OVF;
          end
        end
        PH_HEX: begin
          if (hex_ok && hcount == 3'd4) begin
            d_emit   = 1'b1;
            d_unit   = {hacc, hex_nib(unit_r)};
            d_phase  = PH_TEXT;
            d_hclear = 1'b1;
          end else if (hex_ok) begin
            d_hstore = 1'b1;
          end else begin
            d_phase   = PH_TEXT;
            d_hexfail = 1'b1;
          end
        end
        PH_SKIP: begin
          if (unit_r == CH_SEMI) begin
            d_phase = PH_TEXT;
          end
        end
        default: begin
          d_emit  = t_emit;
          d_phase = t_phase;
        end
      endcase
    end
    d_ovf = (rich_mode && d_is_frac && unit_r == CH_SEMI && phase == PH_FRAC_OVF) ||
            (last_r && d_phase == PH_FRAC_OVF);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: begin
        if (din.valid) begin
          state_next = F_DECODE;
        end
      end
      F_DECODE: begin
        if (!tok_full) begin
          if (d_hexfail) begin
            state_next = F_HEX_U;
          end else if (d_fstart && fend != '0) begin
            state_next = F_FRAC_ADDR;
          end else begin
            state_next = last_r ? F_FLUSH : F_IDLE;
          end
        end
      end
      F_HEX_U: begin
        if (!tok_full) begin
          if (hcount != 3'd0) begin
            state_next = F_HEX_OUT;
          end else begin
            state_next = tail_pend ? F_TAIL : (last_r ? F_FLUSH : F_IDLE);
          end
        end
      end
      F_HEX_OUT: begin
        if (!tok_full && hidx + 3'd1 == hcount) begin
          state_next = tail_pend ? F_TAIL : (last_r ? F_FLUSH : F_IDLE);
        end
      end
      F_TAIL: begin
        if (!tok_full) begin
          state_next = last_r ? F_FLUSH : F_IDLE;
        end
      end
      F_FLUSH: begin
        if ((phase == PH_FRAC || phase == PH_FRAC_OVF) && fend != '0) begin
          state_next = F_FRAC_ADDR;
        end else if (phase == PH_HEX) begin
          state_next = F_HEX_U;
        end else begin
          state_next = F_END;
        end
      end
      F_FRAC_ADDR: state_next = F_FRAC_DATA;
      F_FRAC_DATA: begin
        if (!tok_full) begin
          if (fidx + CW'(1) == fend) begin
            state_next = last_r ? F_FLUSH : F_IDLE;
          end else begin
            state_next = F_FRAC_ADDR;
          end
        end
      end
      F_END: begin
        if (!tok_full) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  // outputs and datapath updates
  always_comb begin
    din.ready      = (state == F_IDLE);
    tok_push       = 1'b0;
    tok.unit       = unit_r;
    tok.is_end     = 1'b0;
    tok.first      = first_pend;
    tok.ovf        = item_ovf;
    tok.last       = last_r;
    phase_next     = phase;
    tail_pend_next = tail_pend;
    fcount_next    = fcount;
    fend_next      = fend;
    fidx_next      = fidx;
    hcount_next    = hcount;
    hidx_next      = hidx;
    hacc_next      = hacc;
    fwe            = 1'b0;
    fwd            = v;
    hwe            = 1'b0;
    unique case (state)
      F_DECODE: begin
        tok.unit = d_unit;
        tok.ovf  = d_ovf;
        if (!tok_full) begin
          tok_push   = d_emit;
          phase_next = d_phase;
          if (d_fclear) begin
            fcount_next = '0;
            fend_next   = '0;
          end
          if (d_fstore) begin
            fwe         = 1'b1;
            fcount_next = fcount + CW'(1);
            if (!is_space(v)) begin
              fend_next = fcount + CW'(1);
            end
          end
          if (d_fstart) begin
            fcount_next = '0;
            fidx_next   = '0;
          end
          if (d_hclear) begin
            hcount_next = 3'd0;
          end
          if (d_hstore) begin
            hwe         = 1'b1;
            hcount_next = hcount + 3'd1;
            hacc_next   = {hacc[7:0], hex_nib(unit_r)};
          end
          if (d_hexfail) begin
            tail_pend_next = 1'b1;
          end
        end
      end
      F_HEX_U: begin
        tok.unit  = CH_U;
        tok_push  = !tok_full;
        hidx_next = 3'd0;
        if (!tok_full && hcount == 3'd0) begin
          hcount_next = 3'd0;
        end
      end
      F_HEX_OUT: begin
        tok.unit = hstore[hidx[1:0]];
        tok_push = !tok_full;
        if (!tok_full) begin
          hidx_next = hidx + 3'd1;
          if (hidx + 3'd1 == hcount) begin
            hcount_next = 3'd0;
          end
        end
      end
      F_TAIL: begin
        if (!tok_full) begin
          tok_push   = t_emit;
          phase_next = t_phase;
        end
      end
      F_FLUSH: begin
        phase_next     = PH_TEXT;
        tail_pend_next = 1'b0;
        fcount_next    = '0;
        fidx_next      = '0;
        if (phase != PH_FRAC && phase != PH_FRAC_OVF) begin
          fend_next = '0;
        end
      end
      F_FRAC_DATA: begin
        tok.unit = frd;
        tok_push = !tok_full;
        if (!tok_full) begin
          fidx_next = fidx + CW'(1);
          if (fidx + CW'(1) == fend) begin
            fend_next = '0;
          end
        end
      end
      F_END: begin
        tok.unit   = '0;
        tok.is_end = 1'b1;
        tok_push   = !tok_full;
      end
      default: begin
        tok_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (fwe) begin
      fmem[fcount[AW-1:0]] <= fwd;
    end
    frd <= fmem[fidx[AW-1:0]];
    if (hwe) begin
      hstore[hcount[1:0]] <= unit_r;
    end
    hacc <= hacc_next;
    if (state == F_IDLE && din.valid) begin
      unit_r <= din.code_unit;
      last_r <= din.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= F_IDLE;
      phase      <= PH_TEXT;
      first_pend <= 1'b0;
      item_ovf   <= 1'b0;
      tail_pend  <= 1'b0;
      fcount     <= '0;
      fend       <= '0;
      fidx       <= '0;
      hcount     <= 3'd0;
      hidx       <= 3'd0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      tail_pend <= tail_pend_next;
      fcount    <= fcount_next;
      fend      <= fend_next;
      fidx      <= fidx_next;
      hcount    <= hcount_next;
      hidx      <= hidx_next;
      if (state == F_IDLE && din.valid) begin
        first_pend <= 1'b1;
        item_ovf   <= 1'b0;
      end else begin
        if (tok_push) begin
          first_pend <= 1'b0;
        end
        if (state == F_DECODE && !tok_full) begin
          item_ovf <= d_ovf;
        end
      end
    end
  end

endmodule

@@ design/ctd_back.sv @@
module ctd_back (
  input  logic            clk,
  input  logic            rst,
  input  ctd_pkg::token_t tok,
  input  logic            tok_empty,
  output logic            tok_pop,
  ctd_out_if.source       dout
);
  import ctd_pkg::*;

  pct_phase_t  pphase, s_phase;
  logic        item_emitted;
  logic [15:0] pend_unit [3];
  logic        pend_has  [3];
  logic [1:0]  pn, pi;
  logic        p_end, p_ovf, p_last;
  logic [15:0] s_unit [3];
  logic        s_has  [3];
  logic [1:0]  s_n;
  logic        prior_out;
  logic [15:0] lc;
  logic        busy, out_free, direct_out, hold_adv, hold_flush, hold_out;
  logic        hold_v;
  logic [15:0] hold_unit;
  logic        hold_has, hold_ovf;

  // Results of a string's final item wait in the hold register, so the end
  // flag lands on whichever result turns out to be the last one.
  assign busy       = (pi != pn);
  assign out_free   = !dout.valid || dout.ready;
  assign direct_out = busy && !p_last && out_free;
  assign hold_adv   = busy && p_last && (!hold_v || out_free);
  assign hold_flush = !busy && p_end && hold_v && out_free;
  assign hold_out   = (hold_adv && hold_v) || hold_flush;
  assign tok_pop    = !busy && !tok_empty && !(p_end && hold_v);
  assign prior_out  = tok.first ? 1'b0 : item_emitted;
  assign lc         = (tok.unit >= 16'h0041 && tok.unit <= 16'h005A) ?
                      tok.unit + 16'h0020 : tok.unit;

  // percent codes for one token
  always_comb begin
    s_unit[0] = CH_PCT;
    s_unit[1] = CH_PCT;
    s_unit[2] = tok.unit;
    s_has[0]  = 1'b1;
    s_has[1]  = 1'b1;
    s_has[2]  = 1'b1;
    s_n       = 2'd0;
    s_phase   = PC_NONE;
    if (tok.is_end) begin
      unique case (pphase)
        PC_ONE:  s_n = 2'd1;
        PC_TWO:  s_n = 2'd2;
        default: s_n = 2'd0;
      endcase
      if (pphase != PC_ONE && pphase != PC_TWO && !prior_out) begin
        s_unit[0] = '0;
        s_has[0]  = 1'b0;
        s_n       = 2'd1;
      end
    end else begin
      unique case (pphase)
        PC_ONE: begin
          if (tok.unit == CH_PCT) begin
            s_phase = PC_TWO;
          end else begin
            s_unit[1] = tok.unit;
            s_n       = 2'd2;
          end
        end
        PC_TWO: begin
          priority case (lc)
            16'h0064: begin
              s_unit[0] = SYM_DEGREE;
              s_n       = 2'd1;
            end
            16'h0063: begin
              s_unit[0] = SYM_DIAMETER;
              s_n       = 2'd1;
            end
            16'h0070: begin
              s_unit[0] = SYM_PLUSMIN;
              s_n       = 2'd1;
            end
            16'h0075, 16'h006F: s_n = 2'd0;
            CH_PCT:             s_n = 2'd1;
            default:            s_n = 2'd3;
          endcase
        end
        default: begin
          if (tok.unit == CH_PCT) begin
            s_phase = PC_ONE;
          end else begin
            s_unit[0] = tok.unit;
            s_n       = 2'd1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (tok_pop) begin
      for (int k = 0; k < 3; k++) begin
        pend_unit[k] <= s_unit[k];
        pend_has[k]  <= s_has[k];
      end
      p_end  <= tok.is_end;
      p_ovf  <= tok.ovf;
      p_last <= tok.last;
    end
    if (direct_out) begin
      dout.out_unit          <= pend_unit[pi];
      dout.has_char          <= pend_has[pi];
      dout.end_of_string     <= 1'b0;
      dout.fraction_overflow <= p_ovf;
    end else if (hold_out) begin
      dout.out_unit          <= hold_unit;
      dout.has_char          <= hold_has;
      dout.end_of_string     <= hold_flush;
      dout.fraction_overflow <= hold_ovf;
    end
    if (hold_adv) begin
      hold_unit <= pend_unit[pi];
      hold_has  <= pend_has[pi];
      hold_ovf  <= p_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pphase       <= PC_NONE;
      item_emitted <= 1'b0;
      pn           <= 2'd0;
      pi           <= 2'd0;
      hold_v       <= 1'b0;
      dout.valid   <= 1'b0;
    end else begin
      if (tok_pop) begin
        pphase       <= s_phase;
        item_emitted <= prior_out || (s_n != 2'd0);
        pn           <= s_n;
        pi           <= 2'd0;
      end else if (direct_out || hold_adv) begin
        pi <= pi + 2'd1;
      end
      if (hold_adv) begin
        hold_v <= 1'b1;
      end else if (hold_flush) begin
        hold_v <= 1'b0;
      end
      if (direct_out || hold_out) begin
        dout.valid <= 1'b1;
      end else if (dout.ready) begin
        dout.valid <= 1'b0;
      end
    end
  end

endmodule

@@ design/cad_text_escape_decoder.sv @@
// Each item is accepted, then decoded; a final item also takes a flush and an end marker.
// An item's results leave through the output register; results of a string's final item
// pass a holding stage first. A new item is accepted only once the front is back in idle,
// and the front stalls while the token queue is full.
// A stacked fraction flush reads each buffered unit through the fraction memory read port.
// Reset (rst, synchronous): phases and counters clear, rich_text_mode returns to 1.
module cad_text_escape_decoder #(
  parameter int FRACTION_DEPTH = ctd_pkg::FRACTION_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  ctd_in_if.sink      din,
  ctd_out_if.source   dout,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ctd_pkg::*;

  // Configuration: one register, rich_text_mode, written at byte addresses 0 to 3 (paddr[2] low).
  logic   rich_mode;
  token_t q_wdata, q_rdata;
  logic   q_push, q_full, q_pop, q_empty;

  assign pready = 1'b1;
  assign prdata = {31'b0, rich_mode};

  always_ff @(posedge clk) begin
    if (rst) begin
      rich_mode <= 1'b1;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      rich_mode <= pwdata[0];
    end
  end

  // Front: accept units, run the backslash decoding, hold fraction and hex buffers.
  ctd_front #(.FRACTION_DEPTH(FRACTION_DEPTH)) u_front (
    .clk      (clk),
    .rst      (rst),
    .rich_mode(rich_mode),
    .din      (din),
    .tok      (q_wdata),
    .tok_push (q_push),
    .tok_full (q_full)
  );

  // Short token queue decouples the two halves.
  ctd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .wdata(q_wdata),
    .full (q_full),
    .pop  (q_pop),
    .rdata(q_rdata),
    .empty(q_empty)
  );

  // Back: percent symbol codes, end markers, output register.
  ctd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .tok      (q_rdata),
    .tok_empty(q_empty),
    .tok_pop  (q_pop),
    .dout     (dout)
  );

endmodule
